>>> rtl/apt_pkg.sv
// ----------------------------------------------------------------------------
// apt_pkg
// shared types and constants of the animation playback timer
// ----------------------------------------------------------------------------
package apt_pkg;

    localparam int TIME_W   = 24;   // Q8.16 time fields
    localparam int DELTA_W  = 20;
    localparam int WEIGHT_W = 17;   // Q1.16
    localparam int FIX8_W   = 16;   // Q8.8
    localparam int TOTAL_W  = 40;
    localparam int STEP_W   = 28;   // (delta * speed) >> 8
    localparam int POS_W    = 30;   // signed position before wrap
    localparam int DVD_W    = 36;   // divider dividend
    localparam int CNT_W    = 6;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_STOP  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    localparam logic [1:0] MODE_BACKWARD = 2'd1;
    localparam logic [1:0] MODE_PINGPONG = 2'd2;

    localparam logic [2:0] REG_ANIM_LENGTH  = 3'd0;
    localparam logic [2:0] REG_SPEED        = 3'd1;
    localparam logic [2:0] REG_BLEND_IN     = 3'd2;
    localparam logic [2:0] REG_BLEND_OUT    = 3'd3;
    localparam logic [2:0] REG_TARGET_W     = 3'd4;
    localparam logic [2:0] REG_LOOP_COUNT   = 3'd5;
    localparam logic [2:0] REG_PLAY_MODE    = 3'd6;
    localparam logic [2:0] REG_START_OFFSET = 3'd7;

    typedef enum logic [1:0] {
        ST_PLAYING  = 2'd0,
        ST_STOPPING = 2'd1,
        ST_STOPPED  = 2'd2
    } t_run;

    typedef enum logic [1:0] {
        DOP_WEIGHT,
        DOP_WRAP,
        DOP_START
    } t_div_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_WDIV,
        S_WCHK,
        S_MUL,
        S_ADV,
        S_WRAP,
        S_TDIV,
        S_SDIV,
        S_DONE
    } t_fsm;

    typedef struct packed {
        logic [TIME_W-1:0]   anim_length;
        logic [FIX8_W-1:0]   speed;
        logic [TIME_W-1:0]   blend_in_time;
        logic [TIME_W-1:0]   default_blend_out;
        logic [WEIGHT_W-1:0] target_weight;
        logic [FIX8_W-1:0]   loop_count;
        logic [1:0]          play_mode;
        logic [TIME_W-1:0]   start_offset;
    } t_cfg;

    typedef struct packed {
        logic    cap;
        logic    div_go;
        t_div_op div_op;
        logic    w_upd;
        logic    mul;
        logic    adv;
        logic    wrap_upd;
        logic    start_upd;
        logic    stop_upd;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req;
        logic       stopped;
        logic       need_wdiv;
        logic       need_tdiv;
        logic       len_zero;
        logic       div_busy;
        logic       div_done;
        logic       out_busy;
    } t_sts;

endpackage

>>> rtl/apt_div.sv
// ----------------------------------------------------------------------------
// apt_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module apt_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic [apt_pkg::DVD_W-1:0]   i_dividend,
    input  logic [apt_pkg::TIME_W-1:0]  i_divisor,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [apt_pkg::DVD_W-1:0]   o_quot,
    output logic [apt_pkg::TIME_W-1:0]  o_rem
);
    import apt_pkg::*;

    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DVD_W-1:0]  r_q;
    logic [TIME_W-1:0] r_rem;
    logic [TIME_W-1:0] r_dvs;
    logic [TIME_W:0]   n_trial;
    logic              n_fit;

    always_comb begin
        n_trial = {r_rem, r_q[DVD_W-1]};
        n_fit   = n_trial >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DVD_W-2:0], n_fit};
            r_rem <= n_fit ? TIME_W'(n_trial - {1'b0, r_dvs}) : n_trial[TIME_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

>>> rtl/apt_ctrl.sv
// ----------------------------------------------------------------------------
// apt_ctrl
// sequencer for tick, stop and start requests
// ----------------------------------------------------------------------------
module apt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  apt_pkg::t_sts i_sts,
    output apt_pkg::t_cmd o_cmd
);
    import apt_pkg::*;

    t_fsm r_state;
    t_fsm n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.div_op = DOP_WEIGHT;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.req)
                    REQ_TICK: begin
                        if (i_sts.stopped) begin
                            n_state = S_DONE;
                        end else if (i_sts.need_wdiv) begin
                            o_cmd.div_go = 1'b1;
                            n_state      = S_WDIV;
                        end else begin
                            o_cmd.w_upd = 1'b1;
                            n_state     = S_WCHK;
                        end
                    end
                    REQ_STOP: begin
                        o_cmd.stop_upd = 1'b1;
                        n_state        = S_DONE;
                    end
                    REQ_START: begin
                        if (i_sts.len_zero) begin
                            o_cmd.start_upd = 1'b1;
                            n_state         = S_DONE;
                        end else begin
                            o_cmd.div_go = 1'b1;
                            o_cmd.div_op = DOP_START;
                            n_state      = S_SDIV;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_WDIV: begin
                if (i_sts.div_done) begin
                    o_cmd.w_upd = 1'b1;
                    n_state     = S_WCHK;
                end
            end
            S_WCHK: n_state = i_sts.stopped ? S_DONE : S_MUL;
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADV;
            end
            S_ADV: begin
                o_cmd.adv = 1'b1;
                n_state   = S_WRAP;
            end
            S_WRAP: begin
                if (i_sts.need_tdiv) begin
                    o_cmd.div_go = 1'b1;
                    o_cmd.div_op = DOP_WRAP;
                    n_state      = S_TDIV;
                end else begin
                    o_cmd.wrap_upd = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_TDIV: begin
                if (i_sts.div_done) begin
                    o_cmd.wrap_upd = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_SDIV: begin
                if (i_sts.div_done) begin
                    o_cmd.start_upd = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_go_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_go |-> !i_sts.div_busy)
        else $error("divider launched while busy");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_sts.out_busy)
        else $error("result register overwritten");

endmodule

>>> rtl/apt_dp.sv
// ----------------------------------------------------------------------------
// apt_dp
// playback state, weight ramp, position wrap and result register
// ----------------------------------------------------------------------------
module apt_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  apt_pkg::t_cfg                 i_cfg,
    input  apt_pkg::t_cmd                 i_cmd,
    output apt_pkg::t_sts                 o_sts,
    input  logic [1:0]                    i_req_type,
    input  logic [apt_pkg::DELTA_W-1:0]   i_delta_time,
    input  logic [apt_pkg::TIME_W-1:0]    i_stop_blend_out,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [apt_pkg::TIME_W-1:0]    o_play_time,
    output logic [apt_pkg::WEIGHT_W-1:0]  o_blend_weight,
    output logic [1:0]                    o_play_state,
    output logic                          o_forward_flag
);
    import apt_pkg::*;

    // captured request
    logic [1:0]          r_req;
    logic [DELTA_W-1:0]  r_delta;
    logic [TIME_W-1:0]   r_sbo;

    // playback state
    logic [TIME_W-1:0]   r_time_pos;
    logic [TOTAL_W-1:0]  r_total;
    logic [WEIGHT_W-1:0] r_weight;
    logic [WEIGHT_W-1:0] r_goal;
    logic [TIME_W-1:0]   r_bo;
    t_run                r_run;
    logic                r_fwd;

    // intermediates
    logic [STEP_W-1:0]        r_step;
    logic [TOTAL_W-1:0]       r_prod;
    logic signed [POS_W-1:0]  r_t;

    // result register
    logic                r_out_valid;
    logic [TIME_W-1:0]   r_out_time;
    logic [WEIGHT_W-1:0] r_out_weight;
    logic [1:0]          r_out_state;
    logic                r_out_fwd;

    logic                     div_busy;
    logic                     div_done;
    logic [DVD_W-1:0]         div_quot;
    logic [TIME_W-1:0]        div_rem;
    logic [DVD_W-1:0]         n_dvd;
    logic [TIME_W-1:0]        n_dvs;
    logic [POS_W-2:0]         n_mag;
    logic                     n_len_zero;
    logic                     n_need_wrap;
    logic [DVD_W:0]           n_wsum;
    logic [DELTA_W+FIX8_W-1:0] n_mul;
    logic signed [POS_W-1:0]  n_t;
    logic [TOTAL_W:0]         n_tot_sum;
    logic [TOTAL_W-1:0]       n_tot;
    logic [TOTAL_W:0]         n_chk;
    logic                     n_loop_end;
    logic [TIME_W-1:0]        n_len_minus;

    always_comb begin
        n_len_zero  = i_cfg.anim_length == '0;
        n_mag       = r_t[POS_W-1] ? (POS_W-1)'(-r_t) : r_t[POS_W-2:0];
        n_need_wrap = r_t[POS_W-1] || (r_t > $signed({6'b0, i_cfg.anim_length}));
        n_len_minus = i_cfg.anim_length - div_rem;

        case (i_cmd.div_op)
            DOP_WRAP: begin
                n_dvd = DVD_W'(n_mag);
                n_dvs = i_cfg.anim_length;
            end
            DOP_START: begin
                n_dvd = DVD_W'(i_cfg.start_offset);
                n_dvs = i_cfg.anim_length;
            end
            default: begin
                n_dvd = {r_delta, 16'b0};
                n_dvs = (r_run == ST_STOPPING) ? r_bo : i_cfg.blend_in_time;
            end
        endcase

        n_wsum = {1'b0, div_quot} + (DVD_W+1)'(r_weight);
        n_mul  = r_delta * i_cfg.speed;

        n_t = r_fwd ? $signed({6'b0, r_time_pos}) + $signed({2'b0, r_step})
                    : $signed({6'b0, r_time_pos}) - $signed({2'b0, r_step});
        n_tot_sum  = {1'b0, r_total} + (TOTAL_W+1)'(r_step);
        n_tot      = n_tot_sum[TOTAL_W] ? '1 : n_tot_sum[TOTAL_W-1:0];
        n_chk      = {1'b0, n_tot} + (TOTAL_W+1)'(r_bo);
        n_loop_end = (r_run == ST_PLAYING) && (i_cfg.loop_count != '0)
                     && ({n_chk, 8'b0} >= (TOTAL_W+9)'(r_prod));
    end

    apt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_cmd.div_go),
        .i_dividend (n_dvd),
        .i_divisor  (n_dvs),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_req   <= i_req_type;
            r_delta <= i_delta_time;
            r_sbo   <= i_stop_blend_out;
        end
        if (i_cmd.mul) begin
            r_step <= n_mul[DELTA_W+FIX8_W-1:8];
            r_prod <= i_cfg.loop_count * i_cfg.anim_length;
        end
        if (i_cmd.adv) begin
            r_t <= n_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_pos <= '0;
            r_total    <= '0;
            r_weight   <= '0;
            r_goal     <= '0;
            r_bo       <= '0;
            r_run      <= ST_STOPPED;
            r_fwd      <= 1'b1;
        end else begin
            if (i_cmd.w_upd) begin
                if (r_run == ST_STOPPING) begin
                    if (r_bo == '0 || div_quot >= DVD_W'(r_weight)) begin
                        r_weight <= '0;
                        r_run    <= ST_STOPPED;
                    end else begin
                        r_weight <= r_weight - div_quot[WEIGHT_W-1:0];
                    end
                end else if (i_cfg.blend_in_time == '0) begin
                    r_weight <= r_goal;
                end else begin
                    r_weight <= (n_wsum >= (DVD_W+1)'(r_goal)) ? r_goal
                                                              : n_wsum[WEIGHT_W-1:0];
                end
            end
            if (i_cmd.adv) begin
                r_total <= n_tot;
                if (n_loop_end) begin
                    r_run  <= ST_STOPPING;
                    r_goal <= '0;
                end
            end
            if (i_cmd.wrap_upd) begin
                if (n_len_zero) begin
                    r_time_pos <= '0;
                end else if (!n_need_wrap) begin
                    r_time_pos <= r_t[TIME_W-1:0];
                end else if (i_cfg.play_mode == MODE_PINGPONG) begin
                    // reflect at either end
                    if (r_t[POS_W-1]) begin
                        r_time_pos <= div_rem;
                        r_fwd      <= 1'b1;
                    end else begin
                        r_time_pos <= n_len_minus;
                        r_fwd      <= 1'b0;
                    end
                end else if (r_t[POS_W-1] && div_rem != '0) begin
                    r_time_pos <= n_len_minus;
                end else begin
                    r_time_pos <= div_rem;
                end
            end
            if (i_cmd.start_upd) begin
                r_time_pos <= n_len_zero ? '0 : div_rem;
                r_total    <= '0;
                r_weight   <= '0;
                r_goal     <= (i_cfg.target_weight > WEIGHT_ONE) ? WEIGHT_ONE
                                                                 : i_cfg.target_weight;
                r_bo       <= i_cfg.default_blend_out;
                r_run      <= ST_PLAYING;
                r_fwd      <= i_cfg.play_mode != MODE_BACKWARD;
            end
            if (i_cmd.stop_upd && r_run != ST_STOPPED) begin
                r_bo   <= r_sbo;
                r_goal <= '0;
                r_run  <= (r_sbo == '0) ? ST_STOPPED : ST_STOPPING;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_time   <= r_time_pos;
            r_out_weight <= r_weight;
            r_out_state  <= r_run;
            r_out_fwd    <= r_fwd;
        end
    end

    always_comb begin
        o_sts.req       = r_req;
        o_sts.stopped   = r_run == ST_STOPPED;
        o_sts.need_wdiv = (r_run == ST_STOPPING) ? (r_bo != '0)
                                                 : (i_cfg.blend_in_time != '0);
        o_sts.need_tdiv = !n_len_zero && n_need_wrap;
        o_sts.len_zero  = n_len_zero;
        o_sts.div_busy  = div_busy;
        o_sts.div_done  = div_done;
        o_sts.out_busy  = r_out_valid && !i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_play_time    = r_out_time;
    assign o_blend_weight = r_out_weight;
    assign o_play_state   = r_out_state;
    assign o_forward_flag = r_out_fwd;

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_weight <= WEIGHT_ONE)
        else $error("blend weight above one");

    a_goal_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run != ST_PLAYING |-> r_goal == '0)
        else $error("weight goal left set while not playing");

endmodule

>>> rtl/animation_playback_timer.sv
// ----------------------------------------------------------------------------
// animation_playback_timer
// playback clock with blend weight, apb configuration and request channel
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  request   in         i_in_valid / o_in_ready   req_type, delta_time, stop_blend_out
//  result    out        o_out_valid / i_out_ready play_time, blend_weight, play_state,
//                                                 forward_flag
//  config    in         psel / penable / pready   paddr, pwdata, prdata
//
//  the shared 36-step divider does one run for the weight ramp,
//  one for the position wrap, one for the start offset
//  one request is in work at a time; the next is taken once the result sits
//  in the output register, even while that register waits on i_out_ready
//  reset is synchronous, active low; it restores every configuration register default and
//  leaves the clock stopped with forward direction
// ----------------------------------------------------------------------------
module animation_playback_timer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request transfer
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_req_type,
    input  logic [apt_pkg::DELTA_W-1:0]   i_delta_time,
    input  logic [apt_pkg::TIME_W-1:0]    i_stop_blend_out,
    // result transfer
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [apt_pkg::TIME_W-1:0]    o_play_time,
    output logic [apt_pkg::WEIGHT_W-1:0]  o_blend_weight,
    output logic [1:0]                    o_play_state,
    output logic                          o_forward_flag,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import apt_pkg::*;

    t_cfg       r_cfg;
    t_cmd       cmd;
    t_sts       sts;
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    // apb write lands in the access phase
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.anim_length       <= 24'd65536;
            r_cfg.speed             <= 16'd256;
            r_cfg.blend_in_time     <= '0;
            r_cfg.default_blend_out <= '0;
            r_cfg.target_weight     <= WEIGHT_ONE;
            r_cfg.loop_count        <= '0;
            r_cfg.play_mode         <= '0;
            r_cfg.start_offset      <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ANIM_LENGTH:  r_cfg.anim_length       <= pwdata[TIME_W-1:0];
                REG_SPEED:        r_cfg.speed             <= pwdata[FIX8_W-1:0];
                REG_BLEND_IN:     r_cfg.blend_in_time     <= pwdata[TIME_W-1:0];
                REG_BLEND_OUT:    r_cfg.default_blend_out <= pwdata[TIME_W-1:0];
                REG_TARGET_W:     r_cfg.target_weight     <= pwdata[WEIGHT_W-1:0];
                REG_LOOP_COUNT:   r_cfg.loop_count        <= pwdata[FIX8_W-1:0];
                REG_PLAY_MODE:    r_cfg.play_mode         <= pwdata[1:0];
                REG_START_OFFSET: r_cfg.start_offset      <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (cfg_idx)
            REG_ANIM_LENGTH:  prdata = 32'(r_cfg.anim_length);
            REG_SPEED:        prdata = 32'(r_cfg.speed);
            REG_BLEND_IN:     prdata = 32'(r_cfg.blend_in_time);
            REG_BLEND_OUT:    prdata = 32'(r_cfg.default_blend_out);
            REG_TARGET_W:     prdata = 32'(r_cfg.target_weight);
            REG_LOOP_COUNT:   prdata = 32'(r_cfg.loop_count);
            REG_PLAY_MODE:    prdata = 32'(r_cfg.play_mode);
            REG_START_OFFSET: prdata = 32'(r_cfg.start_offset);
            default:          prdata = '0;
        endcase
    end

    // sequencer
    apt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // state, arithmetic and result register
    apt_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_req_type       (i_req_type),
        .i_delta_time     (i_delta_time),
        .i_stop_blend_out (i_stop_blend_out),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_play_time      (o_play_time),
        .o_blend_weight   (o_blend_weight),
        .o_play_state     (o_play_state),
        .o_forward_flag   (o_forward_flag)
    );

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.cap |=> !o_in_ready)
        else $error("request taken while another is in work");

endmodule
